FILE: hdl/ouart_pkg.sv
// shared types and constants for the oversampled uart transmitter
package ouart_pkg;

    localparam int unsigned LEN_W  = 7;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned DATA_W = 8;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_COMMIT = 2'd2
    } req_t;

    typedef struct packed {
        logic line_level;
        logic accepted;
        logic busy_res;
    } result_t;

endpackage

FILE: hdl/oversampled_uart_transmitter.sv
// top level: message buffer, frame sequencer and result output
//
//   channel | handshake            | fields
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | req_type, byte_index, data_byte, msg_length
//   out     | out_valid / out_stall| line_level, accepted, busy_res
//
// one word is taken per clock while in_stall is low; its result is registered.
// the next buffer byte is registered from the message memory in advance, so a
// frame load on a tick sees it without a combinational memory read.
// reset clears all control state and sets the line idle high; the message
// memory is not cleared.
// a stalled output keeps its word; one more word goes to the skid stage and
// then in_stall rises until the output drains.
module oversampled_uart_transmitter #(
    parameter int unsigned BUF_BYTES    = 64,
    parameter int unsigned LEAD_SUBBITS = 3,
    parameter int unsigned BIT_SUBBITS  = 5,
    parameter int unsigned STOP_SUBBITS = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [5:0] byte_index,
    input  logic [7:0] data_byte,
    input  logic [6:0] msg_length,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_level,
    output logic       accepted,
    output logic       busy_res
);

    localparam int unsigned FRAME = LEAD_SUBBITS + 9 * BIT_SUBBITS + STOP_SUBBITS;
    localparam int unsigned SPW   = $clog2(FRAME + 1);
    localparam int unsigned AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int unsigned LW    = ouart_pkg::LEN_W;
    localparam int unsigned DW    = ouart_pkg::DATA_W;

    logic [DW-1:0]  store_mem [BUF_BYTES];
    logic [DW-1:0]  rd_data_reg;

    logic [LW-1:0]  msg_len_reg,  msg_len_next;
    logic [LW-1:0]  next_pos_reg, next_pos_next;
    logic [DW-1:0]  cur_byte_reg, cur_byte_next;
    logic [SPW-1:0] subbit_reg,   subbit_next;
    logic           frame_active_reg, frame_active_next;
    logic           pin_reg,      pin_next;

    logic           in_fire;
    logic           wr_en;
    logic           acc;
    logic           frame_done;
    logic           load;
    logic [DW-1:0]  lvl_byte;
    logic [SPW-1:0] lvl_pos;
    logic           lvl;
    ouart_pkg::result_t res;
    ouart_pkg::result_t out_word;

    // line level of sub-bit pos within the frame carrying byte b
    function automatic logic level_of(input logic [DW-1:0] b, input logic [SPW-1:0] pos);
        logic l;
        l = 1'b1;
        if (pos >= SPW'(LEAD_SUBBITS))
            l = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (pos >= SPW'(LEAD_SUBBITS + BIT_SUBBITS * (i + 1)))
                l = b[i];
        end
        if (pos >= SPW'(LEAD_SUBBITS + 9 * BIT_SUBBITS))
            l = 1'b1;
        return l;
    endfunction

    assign in_fire    = in_valid && !in_stall;
    assign frame_done = !frame_active_reg || (subbit_reg >= SPW'(FRAME));
    assign load       = frame_done && (msg_len_reg != '0) && (next_pos_reg < msg_len_reg);
    assign lvl_byte   = load ? rd_data_reg : cur_byte_reg;
    assign lvl_pos    = load ? '0 : subbit_reg;
    assign lvl        = level_of(lvl_byte, lvl_pos);

    always_comb
    begin
        msg_len_next      = msg_len_reg;
        next_pos_next     = next_pos_reg;
        cur_byte_next     = cur_byte_reg;
        subbit_next       = subbit_reg;
        frame_active_next = frame_active_reg;
        pin_next          = pin_reg;
        wr_en             = 1'b0;
        acc               = 1'b0;
        if (in_fire)
        begin
            unique case (ouart_pkg::req_t'(req_type))
                ouart_pkg::REQ_TICK:
                begin
                    if (frame_done)
                    begin
                        if (load)
                        begin
                            cur_byte_next     = rd_data_reg;
                            next_pos_next     = next_pos_reg + LW'(1);
                            frame_active_next = 1'b1;
                            subbit_next       = SPW'(1);
                            pin_next          = lvl;
                        end
                        else
                        begin
                            next_pos_next = '0;
                            msg_len_next  = '0;
                        end
                    end
                    else
                    begin
                        pin_next    = lvl;
                        subbit_next = subbit_reg + SPW'(1);
                    end
                end
                ouart_pkg::REQ_WRITE:
                begin
                    if ((msg_len_reg == '0) && ({1'b0, byte_index} < LW'(BUF_BYTES)))
                    begin
                        wr_en = 1'b1;
                        acc   = 1'b1;
                    end
                end
                ouart_pkg::REQ_COMMIT:
                begin
                    if ((msg_len_reg == '0) && (msg_length != '0)
                        && (msg_length <= LW'(BUF_BYTES)))
                    begin
                        msg_len_next  = msg_length;
                        next_pos_next = '0;
                        acc           = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg      <= '0;
            next_pos_reg     <= '0;
            cur_byte_reg     <= '0;
            subbit_reg       <= '0;
            frame_active_reg <= 1'b0;
            pin_reg          <= 1'b1;
        end
        else
        begin
            msg_len_reg      <= msg_len_next;
            next_pos_reg     <= next_pos_next;
            cur_byte_reg     <= cur_byte_next;
            subbit_reg       <= subbit_next;
            frame_active_reg <= frame_active_next;
            pin_reg          <= pin_next;
        end
    end

    // message memory, read ahead at the position of the next load
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[byte_index[AW-1:0]] <= data_byte;
        rd_data_reg <= store_mem[next_pos_next[AW-1:0]];
    end

    assign res.line_level = pin_next;
    assign res.accepted   = acc;
    assign res.busy_res   = (msg_len_next != '0);

    ouart_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign line_level = out_word.line_level;
    assign accepted   = out_word.accepted;
    assign busy_res   = out_word.busy_res;

endmodule

FILE: hdl/ouart_skid.sv
// output register with skid stage for the result words
module ouart_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  ouart_pkg::result_t res,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output ouart_pkg::result_t out_word
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    ouart_pkg::result_t out_word_reg;
    ouart_pkg::result_t out_word_next;
    ouart_pkg::result_t skid_word_reg;
    ouart_pkg::result_t skid_word_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_word_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            // output held, park the new word
            skid_word_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
